[hdl/pod_pkg.sv]
// Shared types and constants of the pixel optical density block.
package pod_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int DENSITY_BITS      = 16;
    localparam int DENSITY_FRAC_BITS = 12;
    localparam int FLOOR_BITS        = 16;
    localparam int LOG_FRAC          = 20;
    localparam int MANT_FRAC         = 30;
    localparam int MANT_BITS         = MANT_FRAC + 1;
    localparam int EXP_BITS          = $clog2(SAMPLE_BITS);
    localparam int CFG_ADDR_BITS     = 3;
    localparam int CFG_DATA_BITS     = 32;

    localparam logic [31:0]           LN2_Q32     = 32'd2977044472;
    localparam logic [FLOOR_BITS-1:0] FLOOR_RESET = 16'd1;

    // Register index, taken from the word address.
    localparam logic REG_PLANE_FLOOR = 1'b0;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] plane_sample;
        logic [SAMPLE_BITS-1:0] baseline_sample;
        logic                   last_pixel;
    } t_pod_in;

    typedef struct packed {
        logic [DENSITY_BITS-1:0] density;
        logic                    last_out;
    } t_pod_out;

endpackage

[hdl/pixel_optical_density.sv]
// Pixel optical density pipeline: ln(baseline / plane) per pixel in unsigned fixed point.
//
// One pixel enters per clock while the pipeline does not stall. Both samples are clamped
// up to plane_floor (a floor of 0 acts as 1), normalized by a leading-one search, and run
// through a chain of LOG_FRAC squaring stages, one log2 fraction bit and one 31x31
// multiply per operand per stage; that chain makes up most of the pipeline. A subtract
// stage, a multiply-by-ln2 stage and a round-and-saturate stage follow. Each stage stalls
// only when it is full and the stage after it cannot load, so bubbles close up and new
// pixels keep being accepted while a finished result waits at the output, as long as a
// bubble remains. The density is zero when the baseline is not above the plane sample
// and saturates at the top code. plane_floor is written through the APB port at byte
// address 0; write it only while the pipeline is empty.
module pixel_optical_density #(
    parameter int DENSITY_FRAC_BITS = pod_pkg::DENSITY_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  pod_pkg::t_pod_in                    i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pod_pkg::t_pod_out                   o_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [pod_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  logic [pod_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [pod_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready
);

    localparam int SB        = pod_pkg::SAMPLE_BITS;
    localparam int DB        = pod_pkg::DENSITY_BITS;
    localparam int LF        = pod_pkg::LOG_FRAC;
    localparam int MB        = pod_pkg::MANT_BITS;
    localparam int EB        = pod_pkg::EXP_BITS;
    localparam int SH_BITS   = $clog2(MB);
    localparam int LOG_BITS  = EB + LF;
    localparam int PROD_BITS = LOG_BITS + 32;
    localparam int SHIFT     = LF + 32 - DENSITY_FRAC_BITS;
    localparam int RND_BITS  = PROD_BITS + 1 - SHIFT;
    localparam int RW        = (RND_BITS > DB + 1) ? RND_BITS : DB + 1;
    localparam int NSTAGE    = LF + 5;
    localparam int ST_DIFF   = LF + 2;
    localparam int ST_PROD   = LF + 3;
    localparam int ST_OUT    = LF + 4;

    // Position of the highest set bit; x is never zero here.
    function automatic logic [EB-1:0] lead_one(input logic [SB-1:0] x);
        logic [EB-1:0] e;
        e = '0;
        for (int i = 0; i < SB; i++) begin
            if (x[i]) begin
                e = EB'(i);
            end
        end
        return e;
    endfunction

    // Place the leading one at bit MANT_FRAC (Q1.30).
    function automatic logic [MB-1:0] normalize(input logic [SB-1:0] x,
                                                input logic [EB-1:0] e);
        logic [SH_BITS-1:0] sh;
        sh = SH_BITS'(pod_pkg::MANT_FRAC) - SH_BITS'(e);
        return MB'(x) << sh;
    endfunction

    // One squaring step: {fraction bit, next mantissa}.
    function automatic logic [MB:0] square_step(input logic [MB-1:0] m);
        logic [2*MB-1:0] sq;
        logic [MB:0]     t;
        sq = m * m;
        t  = sq[2*MB-1:pod_pkg::MANT_FRAC];
        if (t[MB]) begin
            return {1'b1, t[MB:1]};
        end else begin
            return {1'b0, t[MB-1:0]};
        end
    endfunction

    logic [pod_pkg::FLOOR_BITS-1:0] r_floor;

    logic [NSTAGE-1:0] r_vld;
    logic [NSTAGE-1:0] stage_en;
    logic [ST_OUT-1:0] r_last;
    logic [ST_DIFF-1:0] r_gt;

    logic [SB-1:0] r_val;
    logic [SB-1:0] r_base;

    logic [MB-1:0] r_mb [LF+1];
    logic [MB-1:0] r_mv [LF+1];
    logic [LF-1:0] r_fb [LF+1];
    logic [LF-1:0] r_fv [LF+1];
    logic [EB-1:0] r_eb [LF+1];
    logic [EB-1:0] r_ev [LF+1];

    logic [LOG_BITS-1:0]  r_diff;
    logic [PROD_BITS-1:0] r_prod;
    pod_pkg::t_pod_out    r_out;

    logic [SB-1:0]        floor_v;
    logic [SB-1:0]        n_val;
    logic [SB-1:0]        n_base;
    logic [EB-1:0]        n_eb;
    logic [EB-1:0]        n_ev;
    logic [LOG_BITS-1:0]  n_diff;
    logic [PROD_BITS:0]   rnd_sum;
    logic [RW-1:0]        rnd;
    logic [DB-1:0]        n_density;
    logic                 in_xfer;
    logic                 cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= pod_pkg::FLOOR_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                pod_pkg::REG_PLANE_FLOOR: r_floor <= pwdata[pod_pkg::FLOOR_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            pod_pkg::REG_PLANE_FLOOR: prdata = pod_pkg::CFG_DATA_BITS'(r_floor);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- flow control ----------------
    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        stage_en[NSTAGE-1] = !r_vld[NSTAGE-1] || i_out_ready;
        for (int k = NSTAGE - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign o_in_ready  = stage_en[0];
    assign in_xfer     = i_in_valid && o_in_ready;
    assign o_out_valid = r_vld[NSTAGE-1];
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NSTAGE; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: floor clamp ----------------
    always_comb begin
        floor_v = SB'(r_floor);
        if (floor_v == '0) begin
            floor_v = SB'(1);
        end
        n_val  = (i_in.plane_sample    < floor_v) ? floor_v : i_in.plane_sample;
        n_base = (i_in.baseline_sample < floor_v) ? floor_v : i_in.baseline_sample;
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_val     <= n_val;
            r_base    <= n_base;
            r_gt[0]   <= n_base > n_val;
            r_last[0] <= i_in.last_pixel;
        end
    end

    // ---------------- stage 1: exponent and normalize ----------------
    assign n_eb = lead_one(r_base);
    assign n_ev = lead_one(r_val);

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_eb[0]   <= n_eb;
            r_ev[0]   <= n_ev;
            r_mb[0]   <= normalize(r_base, n_eb);
            r_mv[0]   <= normalize(r_val, n_ev);
            r_fb[0]   <= '0;
            r_fv[0]   <= '0;
            r_gt[1]   <= r_gt[0];
            r_last[1] <= r_last[0];
        end
    end

    // ---------------- squaring chain: one fraction bit per stage ----------------
    for (genvar j = 0; j < LF; j++) begin : g_sq
        logic [MB:0] step_b;
        logic [MB:0] step_v;

        assign step_b = square_step(r_mb[j]);
        assign step_v = square_step(r_mv[j]);

        always_ff @(posedge i_clk) begin
            if (stage_en[j+2]) begin
                r_mb[j+1]   <= step_b[MB-1:0];
                r_mv[j+1]   <= step_v[MB-1:0];
                r_fb[j+1]   <= {r_fb[j][LF-2:0], step_b[MB]};
                r_fv[j+1]   <= {r_fv[j][LF-2:0], step_v[MB]};
                r_eb[j+1]   <= r_eb[j];
                r_ev[j+1]   <= r_ev[j];
                r_gt[j+2]   <= r_gt[j+1];
                r_last[j+2] <= r_last[j+1];
            end
        end
    end

    // ---------------- log difference, ln2 scale, round ----------------
    // With the baseline above the plane sample its log is never smaller.
    assign n_diff = r_gt[ST_DIFF-1] ? ({r_eb[LF], r_fb[LF]} - {r_ev[LF], r_fv[LF]})
                                    : '0;

    assign rnd_sum = {1'b0, r_prod} + ((PROD_BITS + 1)'(1) << (SHIFT - 1));
    assign rnd     = RW'(rnd_sum >> SHIFT);
    assign n_density = (|rnd[RW-1:DB]) ? {DB{1'b1}} : rnd[DB-1:0];

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_DIFF]) begin
            r_diff          <= n_diff;
            r_last[ST_DIFF] <= r_last[ST_DIFF-1];
        end
        if (stage_en[ST_PROD]) begin
            r_prod          <= PROD_BITS'(r_diff) * PROD_BITS'(pod_pkg::LN2_Q32);
            r_last[ST_PROD] <= r_last[ST_PROD-1];
        end
        if (stage_en[ST_OUT]) begin
            r_out.density  <= n_density;
            r_out.last_out <= r_last[ST_OUT-1];
        end
    end

    // ---------------- assertions ----------------
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_vld[0])
        else $error("accepted pixel did not land in the first stage");

    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled while the output side is free");

    a_mant_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[LF+1] |-> (r_mb[LF][MB-1] && r_mv[LF][MB-1]))
        else $error("mantissa left the range one to two");

endmodule
